@@ src/start_time_fair_queue_scheduler_defines.svh @@
// Assertion macros for the start-time fair queuing scheduler.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef START_TIME_FAIR_QUEUE_SCHEDULER_DEFINES_SVH
`define START_TIME_FAIR_QUEUE_SCHEDULER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define STFQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define STFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/stfq_pkg.sv @@
// Shared types and constants of the start-time fair queuing scheduler.
// No dependencies.
package stfq_pkg;

  localparam int unsigned TagW    = 48;
  localparam int unsigned IdW     = 16;
  localparam int unsigned SizeW   = 20;
  localparam int unsigned WeightW = 20;
  localparam int unsigned ProdW   = SizeW + WeightW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 20;
  localparam int unsigned NumWeights = 4;

  localparam logic [CfgIdxW-1:0] CfgActiveApps = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgOutLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgWeight0    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgWeight1    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWeight2    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgWeight3    = 3'd5;

  typedef enum logic [1:0] {
    KindArrival  = 2'd0,
    KindDispatch = 2'd1,
    KindComplete = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEmpty    = 3'd1,
    StLimit    = 3'd2,
    StFull     = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef struct packed {
    logic capture;
    logic arr_mul;
    logic arr_add;
    logic dsp_chk;
    logic dsp_rd;
    logic dsp_cmp;
    logic dsp_end;
    logic cmp_step;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic arr_refuse;
    logic dsp_refuse;
    logic scan_last;
    logic cmp_end;
  } sts_t;

endpackage

@@ src/stfq_ctrl.sv @@
// Controller state machine of the scheduler.
// Depends on stfq_pkg; drives stfq_dp through cmd_t and reads sts_t.
module stfq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          kind_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output stfq_pkg::cmd_t      cmd_o,
  input  stfq_pkg::sts_t      sts_i
);

  typedef enum logic [8:0] {
    SIdle    = 9'b000000001,
    SArrMul  = 9'b000000010,
    SArrAdd  = 9'b000000100,
    SDspChk  = 9'b000001000,
    SDspRd   = 9'b000010000,
    SDspCmp  = 9'b000100000,
    SDspEnd  = 9'b001000000,
    SCmpScan = 9'b010000000,
    SRes     = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          unique case (stfq_pkg::kind_e'(kind_i))
            stfq_pkg::KindArrival:  state_d = SArrMul;
            stfq_pkg::KindDispatch: state_d = SDspChk;
            stfq_pkg::KindComplete: state_d = SCmpScan;
            default:                state_d = SIdle;
          endcase
        end
      end
      SArrMul: begin
        cmd_o.arr_mul = 1'b1;
        state_d = sts_i.arr_refuse ? SRes : SArrAdd;
      end
      SArrAdd: begin
        cmd_o.arr_add = 1'b1;
        state_d = SRes;
      end
      SDspChk: begin
        cmd_o.dsp_chk = 1'b1;
        state_d = sts_i.dsp_refuse ? SRes : SDspRd;
      end
      SDspRd: begin
        cmd_o.dsp_rd = 1'b1;
        state_d = SDspCmp;
      end
      SDspCmp: begin
        cmd_o.dsp_cmp = 1'b1;
        state_d = sts_i.scan_last ? SDspEnd : SDspRd;
      end
      SDspEnd: begin
        cmd_o.dsp_end = 1'b1;
        state_d = SRes;
      end
      SCmpScan: begin
        cmd_o.cmp_step = 1'b1;
        if (sts_i.cmp_end) begin
          state_d = SRes;
        end
      end
      SRes: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/stfq_dp.sv @@
// Datapath of the scheduler: configuration, queue memory, tags, in-flight table.
// Depends on stfq_pkg; controlled by stfq_ctrl through cmd_t.
module stfq_dp #(
  parameter int unsigned NUM_APPS       = 4,
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned INFLIGHT_DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [stfq_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [stfq_pkg::CfgW-1:0]          cfg_data_i,
  input  logic [1:0]                         app_i,
  input  logic [stfq_pkg::IdW-1:0]           req_id_i,
  input  logic [stfq_pkg::SizeW-1:0]         req_size_i,
  input  stfq_pkg::cmd_t                     cmd_i,
  output stfq_pkg::sts_t                     sts_o,
  output logic [2:0]                         status_o,
  output logic [stfq_pkg::IdW-1:0]           out_id_o,
  output logic [1:0]                         out_app_o,
  output logic [stfq_pkg::TagW-1:0]          out_start_tag_o
);

  localparam int unsigned TagW  = stfq_pkg::TagW;
  localparam int unsigned IdW   = stfq_pkg::IdW;
  localparam int unsigned ProdW = stfq_pkg::ProdW;
  localparam int unsigned AppW  = (NUM_APPS > 1) ? $clog2(NUM_APPS) : 1;
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW  = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
  localparam int unsigned IcW   = $clog2(INFLIGHT_DEPTH + 1);
  localparam int unsigned LimW  = (IcW > 5) ? IcW : 5;
  localparam int unsigned MemDepth = 2 ** (AppW + QW);
  localparam int unsigned EntW  = IdW + 2 * TagW;

  // configuration
  logic [2:0]                     act_q;
  logic [4:0]                     lim_q;
  logic [stfq_pkg::WeightW-1:0]   w_q [stfq_pkg::NumWeights];

  // scheduler state
  logic [TagW-1:0]  vt_q;
  logic [TagW-1:0]  lft_q  [NUM_APPS];
  logic [TagW-1:0]  tailf_q [NUM_APPS];
  logic [QW-1:0]    head_q [NUM_APPS];
  logic [QW-1:0]    tail_q [NUM_APPS];
  logic [CntW-1:0]  cnt_q  [NUM_APPS];
  logic [2:0]       rp_q;
  logic [IcW-1:0]   icnt_q;
  logic [IdW-1:0]   ids_q  [INFLIGHT_DEPTH];

  logic [EntW-1:0]  mem [MemDepth];
  logic [EntW-1:0]  rd_q;

  // working registers
  logic [1:0]              a_q;
  logic [IdW-1:0]          id_q;
  logic [stfq_pkg::SizeW-1:0] size_q;
  logic [TagW-1:0]         stag_q;
  logic [ProdW-1:0]        prod_q;
  logic [2:0]              n_q, p_q, k_q, q_q, best_q;
  logic                    ne_q, found_q;
  logic [TagW-1:0]         btag_q, bftag_q;
  logic [IdW-1:0]          bid_q;
  logic [IcW-1:0]          i_q;

  stfq_pkg::status_e       res_st_q;
  logic [IdW-1:0]          res_id_q;
  logic [1:0]              res_app_q;
  logic [TagW-1:0]         res_tag_q;

  logic [AppW-1:0] ai, qi, bi;
  logic            refuse_arr, refuse_dsp;
  logic [TagW-1:0] stag_sel, ftag, rd_stag, rd_ftag;
  logic [IdW-1:0]  rd_id;
  logic [TagW:0]   fsum;
  logic [2:0]      n_eff, qsum, q_cur, best_nx;
  logic            in_range, hit;

  assign ai = a_q[AppW-1:0];
  assign bi = best_q[AppW-1:0];
  assign refuse_arr = ({1'b0, a_q} >= 3'(NUM_APPS)) ||
                      (cnt_q[ai] == CntW'(QUEUE_DEPTH));
  assign stag_sel = (cnt_q[ai] == '0) ? ((lft_q[ai] > vt_q) ? lft_q[ai] : vt_q)
                                      : tailf_q[ai];
  assign fsum = {1'b0, stag_q} + (TagW + 1)'(prod_q);
  assign ftag = fsum[TagW] ? {TagW{1'b1}} : fsum[TagW-1:0];

  assign n_eff = (act_q == 3'd0) ? 3'd1 :
                 (act_q > 3'(NUM_APPS)) ? 3'(NUM_APPS) : act_q;
  assign qsum  = p_q + k_q;
  assign q_cur = (qsum >= n_q) ? (qsum - n_q) : qsum;
  assign qi    = q_cur[AppW-1:0];
  assign best_nx = (best_q + 3'd1 == n_q) ? 3'd0 : (best_q + 3'd1);
  assign {rd_id, rd_stag, rd_ftag} = rd_q;

  assign refuse_dsp = (LimW'(icnt_q) >= LimW'(lim_q)) ||
                      (icnt_q == IcW'(INFLIGHT_DEPTH));
  assign in_range = (i_q < icnt_q);
  assign hit      = in_range && (ids_q[i_q[IdxW-1:0]] == id_q);

  assign sts_o.arr_refuse = refuse_arr;
  assign sts_o.dsp_refuse = refuse_dsp;
  assign sts_o.scan_last  = (k_q + 3'd1 == n_q);
  assign sts_o.cmp_end    = !in_range || hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 3'd4;
      lim_q  <= 5'd4;
      for (int w = 0; w < stfq_pkg::NumWeights; w++) begin
        w_q[w] <= stfq_pkg::WeightW'(65536);
      end
      vt_q   <= '0;
      rp_q   <= '0;
      icnt_q <= '0;
      for (int a = 0; a < NUM_APPS; a++) begin
        lft_q[a]  <= '0;
        head_q[a] <= '0;
        tail_q[a] <= '0;
        cnt_q[a]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          stfq_pkg::CfgActiveApps: act_q <= cfg_data_i[2:0];
          stfq_pkg::CfgOutLimit:   lim_q <= cfg_data_i[4:0];
          stfq_pkg::CfgWeight0:    w_q[0] <= cfg_data_i;
          stfq_pkg::CfgWeight1:    w_q[1] <= cfg_data_i;
          stfq_pkg::CfgWeight2:    w_q[2] <= cfg_data_i;
          stfq_pkg::CfgWeight3:    w_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.arr_add) begin
        tail_q[ai] <= (tail_q[ai] == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q[ai] + 1'b1;
        cnt_q[ai]  <= cnt_q[ai] + 1'b1;
      end
      if (cmd_i.dsp_end && found_q) begin
        head_q[bi] <= (head_q[bi] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q[bi] + 1'b1;
        cnt_q[bi]  <= cnt_q[bi] - 1'b1;
        if (cnt_q[bi] == CntW'(1)) begin
          lft_q[bi] <= bftag_q;
        end
        icnt_q <= icnt_q + 1'b1;
        vt_q   <= btag_q;
        rp_q   <= best_nx;
      end
      if (cmd_i.cmp_step && hit) begin
        icnt_q <= icnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q     <= app_i;
      id_q    <= req_id_i;
      size_q  <= req_size_i;
      n_q     <= n_eff;
      p_q     <= (rp_q < n_eff) ? rp_q : 3'd0;
      k_q     <= '0;
      found_q <= 1'b0;
      i_q     <= '0;
    end
    if (cmd_i.arr_mul) begin
      stag_q <= stag_sel;
      prod_q <= ProdW'(size_q) * ProdW'(w_q[a_q]);
      if (refuse_arr) begin
        res_st_q  <= stfq_pkg::StFull;
        res_id_q  <= id_q;
        res_app_q <= a_q;
        res_tag_q <= '0;
      end
    end
    if (cmd_i.arr_add) begin
      mem[{ai, tail_q[ai]}] <= {id_q, stag_q, ftag};
      tailf_q[ai] <= ftag;
      res_st_q  <= stfq_pkg::StOk;
      res_id_q  <= id_q;
      res_app_q <= a_q;
      res_tag_q <= stag_q;
    end
    if (cmd_i.dsp_chk && refuse_dsp) begin
      res_st_q  <= stfq_pkg::StLimit;
      res_id_q  <= '0;
      res_app_q <= '0;
      res_tag_q <= '0;
    end
    if (cmd_i.dsp_rd) begin
      q_q  <= q_cur;
      ne_q <= (cnt_q[qi] != '0);
      rd_q <= mem[{qi, head_q[qi]}];
    end
    if (cmd_i.dsp_cmp) begin
      k_q <= k_q + 3'd1;
      if (ne_q && (!found_q || rd_stag < btag_q)) begin
        found_q <= 1'b1;
        best_q  <= q_q;
        btag_q  <= rd_stag;
        bftag_q <= rd_ftag;
        bid_q   <= rd_id;
      end
    end
    if (cmd_i.dsp_end) begin
      if (found_q) begin
        ids_q[icnt_q[IdxW-1:0]] <= bid_q;
        res_st_q  <= stfq_pkg::StOk;
        res_id_q  <= bid_q;
        res_app_q <= best_q[1:0];
        res_tag_q <= btag_q;
      end else begin
        res_st_q  <= stfq_pkg::StEmpty;
        res_id_q  <= '0;
        res_app_q <= '0;
        res_tag_q <= '0;
      end
    end
    if (cmd_i.cmp_step) begin
      res_id_q  <= id_q;
      res_app_q <= '0;
      res_tag_q <= '0;
      if (!in_range) begin
        res_st_q <= stfq_pkg::StNotFound;
      end else if (hit) begin
        res_st_q <= stfq_pkg::StOk;
        for (int j = 0; j < INFLIGHT_DEPTH - 1; j++) begin
          if (IcW'(j) >= i_q) begin
            ids_q[j] <= ids_q[j + 1];
          end
        end
      end else begin
        i_q <= i_q + 1'b1;
      end
    end
    if (cmd_i.res_load) begin
      status_o        <= res_st_q;
      out_id_o        <= res_id_q;
      out_app_o       <= res_app_q;
      out_start_tag_o <= res_tag_q;
    end
  end

endmodule

@@ src/start_time_fair_queue_scheduler.sv @@
// Start-time fair queuing scheduler, top level.
// Steps per word: an arrival multiplies then adds; a dispatch checks the limit, then reads and
//   compares each of the N scanned queues in turn and ends; a completion passes in-flight entries
//   until its id matches or the table ends; a refused arrival or dispatch goes to the result.
// One word at a time; the next accept follows the result load, which waits on out_ready_i.
// Reset (async, low) empties queues, clears tags and in-flight count; queue memory not cleared.
`include "start_time_fair_queue_scheduler_defines.svh"
module start_time_fair_queue_scheduler #(
  parameter int unsigned NUM_APPS       = 4,
  parameter int unsigned QUEUE_DEPTH    = 16,
  parameter int unsigned INFLIGHT_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [1:0]                    app_i,
  input  logic [stfq_pkg::IdW-1:0]      req_id_i,
  input  logic [stfq_pkg::SizeW-1:0]    req_size_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [stfq_pkg::IdW-1:0]      out_id_o,
  output logic [1:0]                    out_app_o,
  output logic [stfq_pkg::TagW-1:0]     out_start_tag_o,
  input  logic                          cfg_we_i,
  input  logic [stfq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [stfq_pkg::CfgW-1:0]     cfg_data_i
);

  stfq_pkg::cmd_t cmd;
  stfq_pkg::sts_t sts;
  logic           dp_busy;
  logic           dsp_accept;

  stfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  stfq_dp #(
    .NUM_APPS       (NUM_APPS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .INFLIGHT_DEPTH (INFLIGHT_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .app_i           (app_i),
    .req_id_i        (req_id_i),
    .req_size_i      (req_size_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .status_o        (status_o),
    .out_id_o        (out_id_o),
    .out_app_o       (out_app_o),
    .out_start_tag_o (out_start_tag_o)
  );

  assign dp_busy    = cmd.arr_mul || cmd.arr_add || cmd.dsp_rd || cmd.dsp_cmp || cmd.cmp_step;
  assign dsp_accept = in_valid_i && in_ready_o && (kind_i == stfq_pkg::KindDispatch);

  `STFQ_ASSERT_SAME(a_no_overwrite, cmd.res_load, !out_valid_o || out_ready_i, "word overwritten")
  `STFQ_ASSERT_SAME(a_idle_accept, in_ready_o, !dp_busy, "accept while busy")
  `STFQ_ASSERT_NEXT(a_dispatch_busy, dsp_accept, !in_ready_o, "dispatch not started")

endmodule
